@@ hdl/fix_tag_value_parser_core_macros.svh @@
// Assertion macros for the FIX tag=value parser core.
// Used by the parser and output queue modules; no other dependencies.
`ifndef FIX_TAG_VALUE_PARSER_CORE_MACROS_SVH
`define FIX_TAG_VALUE_PARSER_CORE_MACROS_SVH
`ifndef SYNTH
`define FTVP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define FTVP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FTVP_ASSERT(lbl, clk, rst_n, prop)
`define FTVP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/fix_tvp_pkg.sv @@
// Shared types and constants for the FIX tag=value parser core.
// No dependencies.
package fix_tvp_pkg;

  localparam int VALUE_LEN_BITS = 16;
  localparam int BODY_LEN_BITS  = 20;

  localparam logic [VALUE_LEN_BITS-1:0] VALUE_MAX = {VALUE_LEN_BITS{1'b1}};
  localparam logic [BODY_LEN_BITS-1:0]  BODY_MAX  = {BODY_LEN_BITS{1'b1}};

  // Output queue; depth must be a power of two and at least 2
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_8   = 8'h38;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [7:0] CH_EQ  = 8'h3d;

  localparam logic [16:0] TAG_BODY_LEN = 17'd9;
  localparam logic [16:0] TAG_CHECKSUM = 17'd10;
  localparam logic [2:0]  TAG_MAX_DIGITS = 3'd5;
  localparam logic [1:0]  CSUM_DIGITS = 2'd3;

  localparam logic [1:0] KIND_VALUE     = 2'd0;
  localparam logic [1:0] KIND_FIELD_END = 2'd1;
  localparam logic [1:0] KIND_SUMMARY   = 2'd2;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_BAD_START = 2'd1;
  localparam logic [1:0] ERR_BAD_TAG   = 2'd2;
  localparam logic [1:0] ERR_BAD_BODY  = 2'd3;

  localparam logic [1:0] CHK_NONE     = 2'd0;
  localparam logic [1:0] CHK_MATCH    = 2'd1;
  localparam logic [1:0] CHK_MISMATCH = 2'd2;

  typedef enum logic [2:0] {
    MODE_START0,
    MODE_START1,
    MODE_TAG,
    MODE_VALUE,
    MODE_HALT
  } mode_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [16:0] tag;
    logic [7:0]  vbyte;
    logic [15:0] vlen;
    logic [1:0]  err;
    logic [1:0]  bs;
    logic [1:0]  cs;
    logic        last;
  } res_t;

  // Up to two result words produced by one input byte
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

@@ hdl/fix_tvp_parse.sv @@
// Parser state and per-byte update for the FIX tag=value parser core.
// Depends on fix_tvp_pkg and the assertion macro header.
`include "fix_tag_value_parser_core_macros.svh"

module fix_tvp_parse import fix_tvp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_message_i,
  output push_t      push_o
);

  localparam int EXP_W = BODY_LEN_BITS + 4;

  mode_e                     mode_q, mode_d;
  logic [16:0]               tag_acc_q, tag_acc_d;
  logic [2:0]                tag_digits_q, tag_digits_d;
  logic [VALUE_LEN_BITS-1:0] value_cnt_q, value_cnt_d;
  logic [7:0]                run_sum_q, run_sum_d;
  logic [7:0]                sum_fs_q, sum_fs_d;
  logic [BODY_LEN_BITS-1:0]  exp_len_q, exp_len_d;
  logic [BODY_LEN_BITS-1:0]  body_cnt_q, body_cnt_d;
  logic                      in9_q, in9_d;
  logic                      done9_q, done9_d;
  logic                      seen10_q, seen10_d;
  logic                      bad9_q, bad9_d;
  logic [9:0]                ct_val_q, ct_val_d;
  logic [1:0]                ct_cnt_q, ct_cnt_d;
  logic                      ct_bad_q, ct_bad_d;
  logic                      ct_done_q, ct_done_d;
  logic [1:0]                err_q, err_d;

  always_comb begin
    logic             dig;
    logic [3:0]       digit;
    logic             do_add;
    logic             do_end_tag;
    logic             fail9;
    logic [EXP_W-1:0] exp10;
    logic [1:0]       err_sum;
    logic [1:0]       bs;
    logic [1:0]       cs;
    res_t             summary;

    dig        = (data_byte_i >= CH_0) && (data_byte_i <= CH_9);
    digit      = 4'(data_byte_i - CH_0);
    do_add     = 1'b0;
    do_end_tag = 1'b0;
    fail9      = 1'b0;
    exp10      = (EXP_W'(exp_len_q) << 3) + (EXP_W'(exp_len_q) << 1) + EXP_W'(digit);
    err_sum    = ERR_NONE;
    bs         = CHK_NONE;
    cs         = CHK_NONE;
    summary    = '0;

    mode_d       = mode_q;
    tag_acc_d    = tag_acc_q;
    tag_digits_d = tag_digits_q;
    value_cnt_d  = value_cnt_q;
    run_sum_d    = run_sum_q;
    sum_fs_d     = sum_fs_q;
    exp_len_d    = exp_len_q;
    body_cnt_d   = body_cnt_q;
    in9_d        = in9_q;
    done9_d      = done9_q;
    seen10_d     = seen10_q;
    bad9_d       = bad9_q;
    ct_val_d     = ct_val_q;
    ct_cnt_d     = ct_cnt_q;
    ct_bad_d     = ct_bad_q;
    ct_done_d    = ct_done_q;
    err_d        = err_q;
    push_o       = '0;

    if (accept_i && (mode_q != MODE_HALT)) begin
      // checksum covers bytes up to the SOH before tag 10
      if (!seen10_q) run_sum_d = run_sum_q + data_byte_i;
      if (done9_q && !seen10_q && (body_cnt_q != BODY_MAX)) begin
        body_cnt_d = body_cnt_q + 1'b1;
      end

      case (mode_q)
        MODE_START0: begin
          if (data_byte_i != CH_8) begin
            err_d  = ERR_BAD_START;
            mode_d = MODE_HALT;
          end else begin
            do_add = 1'b1;
            mode_d = MODE_START1;
          end
        end
        MODE_START1: begin
          if (data_byte_i != CH_EQ) begin
            err_d  = ERR_BAD_START;
            mode_d = MODE_HALT;
          end else begin
            do_end_tag = 1'b1;
          end
        end
        MODE_TAG: begin
          if (dig) begin
            do_add = 1'b1;
          end else if (data_byte_i == CH_EQ) begin
            do_end_tag = 1'b1;
          end else begin
            err_d  = ERR_BAD_TAG;
            mode_d = MODE_HALT;
          end
        end
        MODE_VALUE: begin
          push_o.n = 2'd1;
          push_o.r0.tag = tag_acc_q;
          if (data_byte_i == CH_SOH) begin
            push_o.r0.kind = KIND_FIELD_END;
            push_o.r0.vlen = 16'(value_cnt_q);
            if (in9_q) begin
              in9_d = 1'b0;
              if ((value_cnt_q == '0) || bad9_q) begin
                fail9  = 1'b1;
                err_d  = ERR_BAD_BODY;
                mode_d = MODE_HALT;
              end else begin
                done9_d    = 1'b1;
                body_cnt_d = '0;
              end
            end
            if (!fail9) begin
              if (seen10_q && !ct_done_q) ct_done_d = 1'b1;
              tag_acc_d    = '0;
              tag_digits_d = '0;
              value_cnt_d  = '0;
              sum_fs_d     = run_sum_d;
              mode_d       = MODE_TAG;
            end
          end else begin
            push_o.r0.kind  = KIND_VALUE;
            push_o.r0.vbyte = data_byte_i;
            if (value_cnt_q != VALUE_MAX) value_cnt_d = value_cnt_q + 1'b1;
            if (in9_q) begin
              if (!dig) begin
                bad9_d = 1'b1;
              end else if (exp10 > EXP_W'(BODY_MAX)) begin
                exp_len_d = BODY_MAX;
              end else begin
                exp_len_d = exp10[BODY_LEN_BITS-1:0];
              end
            end
            if (seen10_q && !ct_done_q) begin
              if (!dig || (ct_cnt_q == CSUM_DIGITS)) begin
                ct_bad_d = 1'b1;
              end else begin
                ct_val_d = 10'((ct_val_q << 3) + (ct_val_q << 1) + 10'(digit));
                ct_cnt_d = ct_cnt_q + 1'b1;
              end
            end
          end
        end
        default: ;
      endcase

      if (do_add) begin
        if (tag_digits_q >= TAG_MAX_DIGITS) begin
          err_d  = ERR_BAD_TAG;
          mode_d = MODE_HALT;
        end else begin
          tag_acc_d    = 17'((tag_acc_q << 3) + (tag_acc_q << 1) + 17'(digit));
          tag_digits_d = tag_digits_q + 1'b1;
        end
      end

      if (do_end_tag) begin
        if (tag_digits_q == '0) begin
          err_d  = ERR_BAD_TAG;
          mode_d = MODE_HALT;
        end else begin
          if ((tag_acc_q == TAG_BODY_LEN) && !done9_q && !seen10_q) in9_d = 1'b1;
          if ((tag_acc_q == TAG_CHECKSUM) && !seen10_q) begin
            seen10_d  = 1'b1;
            run_sum_d = sum_fs_q;
            // take back the tag digits and '=' counted since the SOH
            if (done9_q && (body_cnt_d != BODY_MAX)) begin
              body_cnt_d = body_cnt_d - BODY_LEN_BITS'(tag_digits_q) - 1'b1;
            end
          end
          mode_d = MODE_VALUE;
        end
      end
    end

    if (accept_i && end_of_message_i) begin
      err_sum = err_d;
      if ((err_d == ERR_NONE) && ((mode_d == MODE_START0) || (mode_d == MODE_START1))) begin
        err_sum = ERR_BAD_START;
      end
      if (err_sum == ERR_NONE) begin
        if (done9_d) begin
          if (!seen10_d || (body_cnt_d == BODY_MAX) || (exp_len_d == BODY_MAX)) begin
            bs = CHK_MISMATCH;
          end else begin
            bs = (body_cnt_d == exp_len_d) ? CHK_MATCH : CHK_MISMATCH;
          end
        end
        if (ct_done_d) begin
          cs = ((ct_cnt_d == CSUM_DIGITS) && !ct_bad_d && (ct_val_d == {2'b00, run_sum_d}))
               ? CHK_MATCH : CHK_MISMATCH;
        end
      end
      summary.kind = KIND_SUMMARY;
      summary.err  = err_sum;
      summary.bs   = bs;
      summary.cs   = cs;
      if (push_o.n == 2'd0) begin
        push_o.r0 = summary;
        push_o.n  = 2'd1;
      end else begin
        push_o.r1 = summary;
        push_o.n  = 2'd2;
      end

      // back to the start state for the next message
      mode_d       = MODE_START0;
      tag_acc_d    = '0;
      tag_digits_d = '0;
      value_cnt_d  = '0;
      run_sum_d    = '0;
      sum_fs_d     = '0;
      exp_len_d    = '0;
      body_cnt_d   = '0;
      in9_d        = 1'b0;
      done9_d      = 1'b0;
      seen10_d     = 1'b0;
      bad9_d       = 1'b0;
      ct_val_d     = '0;
      ct_cnt_d     = '0;
      ct_bad_d     = 1'b0;
      ct_done_d    = 1'b0;
      err_d        = ERR_NONE;
    end

    push_o.r0.last = (push_o.n == 2'd1);
    push_o.r1.last = (push_o.n == 2'd2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_START0;
      tag_acc_q    <= '0;
      tag_digits_q <= '0;
      value_cnt_q  <= '0;
      run_sum_q    <= '0;
      sum_fs_q     <= '0;
      exp_len_q    <= '0;
      body_cnt_q   <= '0;
      in9_q        <= 1'b0;
      done9_q      <= 1'b0;
      seen10_q     <= 1'b0;
      bad9_q       <= 1'b0;
      ct_val_q     <= '0;
      ct_cnt_q     <= '0;
      ct_bad_q     <= 1'b0;
      ct_done_q    <= 1'b0;
      err_q        <= ERR_NONE;
    end else begin
      mode_q       <= mode_d;
      tag_acc_q    <= tag_acc_d;
      tag_digits_q <= tag_digits_d;
      value_cnt_q  <= value_cnt_d;
      run_sum_q    <= run_sum_d;
      sum_fs_q     <= sum_fs_d;
      exp_len_q    <= exp_len_d;
      body_cnt_q   <= body_cnt_d;
      in9_q        <= in9_d;
      done9_q      <= done9_d;
      seen10_q     <= seen10_d;
      bad9_q       <= bad9_d;
      ct_val_q     <= ct_val_d;
      ct_cnt_q     <= ct_cnt_d;
      ct_bad_q     <= ct_bad_d;
      ct_done_q    <= ct_done_d;
      err_q        <= err_d;
    end
  end

  `FTVP_ASSERT(a_halt_has_error, clk_i, rst_ni, (mode_q != MODE_HALT) || (err_q != ERR_NONE))
  `FTVP_ASSERT(a_tag_digits_max, clk_i, rst_ni, tag_digits_q <= TAG_MAX_DIGITS)
  `FTVP_ASSERT(a_body9_exclusive, clk_i, rst_ni, !(in9_q && (done9_q || seen10_q)))
  `FTVP_ASSERT_NEXT(a_eom_restarts, clk_i, rst_ni, accept_i && end_of_message_i, (mode_q == MODE_START0) && (err_q == ERR_NONE))

endmodule

@@ hdl/fix_tvp_outq.sv @@
// Result queue for the FIX tag=value parser core: takes up to two words per
// cycle, hands out one when popped. Depends on fix_tvp_pkg and the assertion macro header.
`include "fix_tag_value_parser_core_macros.svh"

module fix_tvp_outq import fix_tvp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  input  logic  pop_i,
  output res_t  head_o,
  output logic  valid_o,
  output logic  full_o
);

  res_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic              do_pop;

  assign head_o     = mem_q[rd_ptr_q];
  assign valid_o    = (count_q != '0);
  // hold off input unless two free slots remain
  assign full_o     = (count_q > QCNT_W'(QDEPTH - 2));
  assign do_pop     = pop_i && valid_o;
  assign wr_ptr_nxt = wr_ptr_q + 1'b1;

  always_comb begin
    wr_ptr_d = wr_ptr_q + QPTR_W'(push_i.n);
    rd_ptr_d = rd_ptr_q + QPTR_W'(do_pop);
    count_d  = count_q + QCNT_W'(push_i.n) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) mem_q[wr_ptr_q] <= push_i.r0;
    if (push_i.n == 2'd2) mem_q[wr_ptr_nxt] <= push_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `FTVP_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= QCNT_W'(QDEPTH))
  `FTVP_ASSERT(a_push_has_room, clk_i, rst_ni, (push_i.n == 2'd0) || !full_o)

endmodule

@@ hdl/fix_tag_value_parser_core.sv @@
// Top level of the FIX tag=value parser core: byte parser and result queue.
// Depends on fix_tvp_pkg, fix_tvp_parse and fix_tvp_outq.
//
//  channel  direction  handshake                 payload
//  input    in         in_valid_i / in_stall_o   data_byte_i, end_of_message_i
//  result   out        out_valid_o / out_stall_i kind_o, field_tag_o, value_byte_o,
//                                                value_length_o, error_code_o,
//                                                body_length_status_o,
//                                                checksum_status_o, last_o
//
// One byte is taken per cycle while in_stall_o is low; its result words are registered into the queue.
// A byte gives zero, one or two words; the queue drains one word per cycle while out_stall_i is low,
// so the end-of-message byte that adds a summary gives the queue one more word to drain.
// in_stall_o rises when fewer than two of the four queue slots are free.
// Reset is asynchronous, active low, and leaves the parser waiting for "8=".

module fix_tag_value_parser_core import fix_tvp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [16:0] field_tag_o,
  output logic [7:0]  value_byte_o,
  output logic [15:0] value_length_o,
  output logic [1:0]  error_code_o,
  output logic [1:0]  body_length_status_o,
  output logic [1:0]  checksum_status_o,
  output logic        last_o
);

  push_t push;
  res_t  head;
  logic  q_full;
  logic  accept;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  fix_tvp_parse u_parse (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .data_byte_i      (data_byte_i),
    .end_of_message_i (end_of_message_i),
    .push_o           (push)
  );

  fix_tvp_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (!out_stall_i),
    .head_o  (head),
    .valid_o (out_valid_o),
    .full_o  (q_full)
  );

  assign kind_o               = head.kind;
  assign field_tag_o          = head.tag;
  assign value_byte_o         = head.vbyte;
  assign value_length_o       = head.vlen;
  assign error_code_o         = head.err;
  assign body_length_status_o = head.bs;
  assign checksum_status_o    = head.cs;
  assign last_o               = head.last;

endmodule

@@ sim/tb_top.sv @@
// Self-checking bench for fix_tag_value_parser_core: FIX messages in, result words checked.
// Depends on fix_tvp_pkg and the core RTL; predicts every word from a byte-level parser.
`timescale 1ns / 100ps

module tb_top;
  import fix_tvp_pkg::*;

  typedef logic [7:0] octet_q_t[$];

  localparam int CYCLE_LIMIT    = 800000;
  localparam int HOLD_CYCLES    = 300;
  localparam int IDLE_PCT       = 17;
  localparam int DRAIN_WAIT     = 16;
  localparam int MAX_PRINTS     = 30;
  localparam int LONG_VALUE_LEN = 200;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        end_of_message_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  kind_o;
  logic [16:0] field_tag_o;
  logic [7:0]  value_byte_o;
  logic [15:0] value_length_o;
  logic [1:0]  error_code_o;
  logic [1:0]  body_length_status_o;
  logic [1:0]  checksum_status_o;
  logic        last_o;

  fix_tag_value_parser_core u_top (.*);

  // Parser prediction state
  mode_e                     prs_mode;
  logic [16:0]               prs_tag;
  int unsigned               prs_tag_digits;
  logic [VALUE_LEN_BITS-1:0] prs_vlen;
  logic [7:0]                prs_sum;
  logic [7:0]                prs_sum_field;
  logic [BODY_LEN_BITS-1:0]  prs_body_expect;
  logic [BODY_LEN_BITS-1:0]  prs_body_count;
  bit                        prs_in9, prs_done9, prs_seen10, prs_bad9;
  logic [9:0]                prs_cs_val;
  int unsigned               prs_cs_digits;
  bit                        prs_cs_bad, prs_cs_done;
  logic [1:0]                prs_err;

  res_t pending_words[$];
  res_t head_word;

  int  error_count, bytes_sent, messages_sent, words_checked;
  int  summaries, body_matches, csum_matches, errored_msgs;
  int  cycle_count;
  bit  no_idle;
  int  hold_asked, hold_taken, hold_left;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever a test asks for one
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (hold_taken != hold_asked) begin
      hold_taken = hold_asked;
      hold_left = HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  //--------------------------------------------------------------------------
  // Prediction
  //--------------------------------------------------------------------------
  function automatic void clear_field();
    prs_tag = '0;
    prs_tag_digits = 0;
    prs_vlen = '0;
  endfunction

  function automatic void parser_reset();
    prs_mode = MODE_START0;
    clear_field();
    prs_sum = '0;
    prs_sum_field = '0;
    prs_body_expect = '0;
    prs_body_count = '0;
    {prs_in9, prs_done9, prs_seen10, prs_bad9} = '0;
    prs_cs_val = '0;
    prs_cs_digits = 0;
    prs_cs_bad = 1'b0;
    prs_cs_done = 1'b0;
    prs_err = ERR_NONE;
  endfunction

  function automatic void halt_on(input logic [1:0] code);
    prs_err = code;
    prs_mode = MODE_HALT;
  endfunction

  function automatic void tag_digit(input logic [7:0] c);
    if (prs_tag_digits >= TAG_MAX_DIGITS) begin
      halt_on(ERR_BAD_TAG);
      return;
    end
    prs_tag = prs_tag * 17'd10 + 17'(c - CH_0);
    prs_tag_digits++;
  endfunction

  function automatic void tag_done();
    if (prs_tag_digits == 0) begin
      halt_on(ERR_BAD_TAG);
      return;
    end
    if (prs_tag == TAG_BODY_LEN && !prs_done9 && !prs_seen10) prs_in9 = 1'b1;
    if (prs_tag == TAG_CHECKSUM && !prs_seen10) begin
      prs_seen10 = 1'b1;
      prs_sum = prs_sum_field;
      // drop the tag 10 digits and '=' from the body count
      if (prs_done9 && prs_body_count != BODY_MAX)
        prs_body_count = prs_body_count - BODY_LEN_BITS'(prs_tag_digits) - 1'b1;
    end
    prs_mode = MODE_VALUE;
  endfunction

  function automatic res_t make_word(input logic [1:0] kind, input logic [16:0] tag,
                                     input logic [7:0] vbyte, input logic [15:0] vlen,
                                     input logic [1:0] err, input logic [1:0] bs,
                                     input logic [1:0] cs);
    res_t w;
    w.kind = kind;
    w.tag = tag;
    w.vbyte = vbyte;
    w.vlen = vlen;
    w.err = err;
    w.bs = bs;
    w.cs = cs;
    w.last = 1'b0;
    return w;
  endfunction

  // Advance the parser by one accepted byte and queue the words it yields
  function automatic void parse_byte(input logic [7:0] c, input logic eom);
    res_t       step_words[$];
    bit         is_digit;
    logic [3:0] digit;
    logic [63:0] wide;
    logic [1:0] bs, cs;
    is_digit = (c >= CH_0) && (c <= CH_9);
    digit = 4'(c - CH_0);
    if (prs_mode != MODE_HALT) begin
      if (!prs_seen10) prs_sum = prs_sum + c;
      if (prs_done9 && !prs_seen10 && prs_body_count != BODY_MAX)
        prs_body_count = prs_body_count + 1'b1;
      case (prs_mode)
        MODE_START0: begin
          if (c != CH_8) halt_on(ERR_BAD_START);
          else begin
            tag_digit(c);
            prs_mode = MODE_START1;
          end
        end
        MODE_START1: begin
          if (c != CH_EQ) halt_on(ERR_BAD_START);
          else tag_done();
        end
        MODE_TAG: begin
          if (is_digit) tag_digit(c);
          else if (c == CH_EQ) tag_done();
          else halt_on(ERR_BAD_TAG);
        end
        default: begin
          if (c == CH_SOH) begin
            step_words.insert(step_words.size(),
                              make_word(KIND_FIELD_END, prs_tag, '0, prs_vlen,
                                        ERR_NONE, CHK_NONE, CHK_NONE));
            if (prs_in9) begin
              prs_in9 = 1'b0;
              if (prs_vlen == 0 || prs_bad9) halt_on(ERR_BAD_BODY);
              else begin
                prs_done9 = 1'b1;
                prs_body_count = '0;
              end
            end
            if (prs_mode != MODE_HALT) begin
              if (prs_seen10) prs_cs_done = 1'b1;
              clear_field();
              prs_sum_field = prs_sum;
              prs_mode = MODE_TAG;
            end
          end else begin
            step_words.insert(step_words.size(),
                              make_word(KIND_VALUE, prs_tag, c, '0,
                                        ERR_NONE, CHK_NONE, CHK_NONE));
            if (prs_vlen != VALUE_MAX) prs_vlen = prs_vlen + 1'b1;
            if (prs_in9) begin
              if (!is_digit) prs_bad9 = 1'b1;
              else begin
                wide = prs_body_expect * 64'd10 + digit;
                prs_body_expect = (wide > BODY_MAX) ? BODY_MAX : wide[BODY_LEN_BITS-1:0];
              end
            end
            if (prs_seen10 && !prs_cs_done) begin
              if (!is_digit || prs_cs_digits == CSUM_DIGITS) prs_cs_bad = 1'b1;
              else begin
                prs_cs_val = prs_cs_val * 10'd10 + digit;
                prs_cs_digits++;
              end
            end
          end
        end
      endcase
    end

    if (eom) begin
      bs = CHK_NONE;
      cs = CHK_NONE;
      if (prs_err == ERR_NONE && (prs_mode == MODE_START0 || prs_mode == MODE_START1))
        prs_err = ERR_BAD_START;
      if (prs_err == ERR_NONE) begin
        if (prs_done9)
          bs = (!prs_seen10 || prs_body_count == BODY_MAX || prs_body_expect == BODY_MAX ||
                prs_body_count != prs_body_expect) ? CHK_MISMATCH : CHK_MATCH;
        if (prs_cs_done)
          cs = (prs_cs_digits == CSUM_DIGITS && !prs_cs_bad && prs_cs_val == prs_sum) ?
               CHK_MATCH : CHK_MISMATCH;
      end
      step_words.insert(step_words.size(),
                        make_word(KIND_SUMMARY, '0, '0, '0, prs_err, bs, cs));
      parser_reset();
    end
    if (step_words.size() > 0) step_words[step_words.size()-1].last = 1'b1;
    foreach (step_words[i]) pending_words.insert(pending_words.size(), step_words[i]);
  endfunction

  //--------------------------------------------------------------------------
  // Checking
  //--------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("word %0d %s = %0h, predicted %0h",
                                words_checked, name, got, want));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("word %0d arrived with nothing pending", words_checked));
      end else begin
        head_word = pending_words.pop_front();
        check_field("kind", kind_o, head_word.kind);
        check_field("field_tag", field_tag_o, head_word.tag);
        check_field("value_byte", value_byte_o, head_word.vbyte);
        check_field("value_length", value_length_o, head_word.vlen);
        check_field("error_code", error_code_o, head_word.err);
        check_field("body_length_status", body_length_status_o, head_word.bs);
        check_field("checksum_status", checksum_status_o, head_word.cs);
        check_field("last", last_o, head_word.last);
        if (head_word.kind == KIND_SUMMARY) begin
          summaries++;
          if (head_word.bs == CHK_MATCH) body_matches++;
          if (head_word.cs == CHK_MATCH) csum_matches++;
          if (head_word.err != ERR_NONE) errored_msgs++;
        end
      end
      words_checked++;
    end
  end

  //--------------------------------------------------------------------------
  // Stimulus helpers
  //--------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] value, input logic eom);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    data_byte_i      <= value;
    end_of_message_i <= eom;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    parse_byte(value, eom);
    bytes_sent++;
  endtask

  task automatic send_msg(input octet_q_t m);
    foreach (m[i]) send_byte(m[i], i == m.size() - 1);
    messages_sent++;
  endtask

  // '|' stands for SOH
  task automatic push_text(ref octet_q_t q, input string s);
    for (int i = 0; i < s.len(); i++) q.insert(q.size(), (s[i] == "|") ? CH_SOH : s[i]);
  endtask

  task automatic push_dec(ref octet_q_t q, input longint unsigned v, input int min_digits);
    string t;
    t = $sformatf("%0d", v);
    while (t.len() < min_digits) t = {"0", t};
    push_text(q, t);
  endtask

  function automatic logic [7:0] value_octet();
    logic [7:0] v;
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(32, 126));
    v = 8'($urandom_range(0, 255));
    return (v == CH_SOH) ? 8'hff : v;
  endfunction

  task automatic random_body(ref octet_q_t q, input int nfields, input int max_vlen);
    int unsigned tag;
    repeat (nfields) begin
      tag = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(11, 99999);
      push_dec(q, tag, ($urandom_range(0, 9) < 2) ? 5 : 1);
      q.insert(q.size(), CH_EQ);
      repeat ($urandom_range(0, max_vlen)) q.insert(q.size(), value_octet());
      q.insert(q.size(), CH_SOH);
    end
  endtask

  // Header, optional BodyLength field, body, optional CheckSum trailer
  task automatic wrap_fix(ref octet_q_t m, input octet_q_t body, input int len_delta,
                          input int sum_delta, input int cs_width, input int tag_zeros,
                          input bit with_len, input bit with_csum);
    logic [7:0] csum;
    string      zeros;
    int         blen;
    zeros = "";
    repeat (tag_zeros) zeros = {zeros, "0"};
    m = {};
    push_text(m, "8=FIX.4.4|");
    if (with_len) begin
      blen = body.size() + len_delta;
      push_text(m, {zeros, "9="});
      push_dec(m, (blen < 0) ? 0 : blen, 1);
      m.insert(m.size(), CH_SOH);
    end
    foreach (body[i]) m.insert(m.size(), body[i]);
    if (with_csum) begin
      csum = 8'(sum_delta);
      foreach (m[i]) csum += m[i];
      push_text(m, {zeros, "10="});
      push_dec(m, csum, cs_width);
      m.insert(m.size(), CH_SOH);
    end
  endtask

  task automatic send_text(input string s);
    octet_q_t m;
    push_text(m, s);
    send_msg(m);
  endtask

  //--------------------------------------------------------------------------
  // Tests
  //--------------------------------------------------------------------------
  task automatic test_start_checks();
    send_text("7");
    send_text("8");
    send_text("8=");
    send_text("8X=1|");
    send_text("8=|");
  endtask

  task automatic test_tag_errors();
    send_text("8=A|=B|");
    send_text("8=A|123456=B|");
    send_text("8=A|35:B|");
  endtask

  task automatic test_body_length_checks();
    octet_q_t body, m;
    send_text("8=A|9=|10=000|");
    send_text("8=A|9=1x|");
    send_text("8=A|10=1a2|");
    push_text(body, "35=0|");
    wrap_fix(m, body, 2000000, 0, 3, 0, 1, 1);
    send_msg(m);
  endtask

  task automatic test_good_messages();
    octet_q_t body, m;
    push_text(body, "99999=");
    body.insert(body.size(), 8'h00);
    body.insert(body.size(), 8'hff);
    body.insert(body.size(), 8'h7f);
    body.insert(body.size(), 8'h80);
    push_text(body, "|00001=x|");
    wrap_fix(m, body, 0, 0, 3, 0, 1, 1);
    send_msg(m);
    // trailing fields after the checksum, ending in a partial field
    wrap_fix(m, body, 0, 0, 3, 2, 1, 1);
    push_text(m, "9=7|10=1");
    send_msg(m);
  endtask

  task automatic test_long_value();
    octet_q_t body, m;
    push_text(body, "58=");
    repeat (LONG_VALUE_LEN) body.insert(body.size(), value_octet());
    body.insert(body.size(), CH_SOH);
    wrap_fix(m, body, 0, 0, 3, 0, 1, 1);
    send_msg(m);
  endtask

  task automatic test_random_messages(input int byte_target);
    octet_q_t body, m;
    int       pick, start_count, keep;
    start_count = bytes_sent;
    while (bytes_sent - start_count < byte_target) begin
      body = {};
      random_body(body, $urandom_range(1, 6), 12);
      pick = $urandom_range(0, 99);
      if (pick < 55)
        wrap_fix(m, body, 0, 0, 3, 0, 1, 1);
      else if (pick < 63)
        wrap_fix(m, body, $urandom_range(0, 1) ? $urandom_range(1, 3) : -$urandom_range(1, 3),
                 0, 3, 0, 1, 1);
      else if (pick < 71)
        wrap_fix(m, body, 0, $urandom_range(1, 255), 3, 0, 1, 1);
      else if (pick < 77)
        wrap_fix(m, body, 0, 0, 3, $urandom_range(1, 3), 1, 1);
      else if (pick < 81)
        wrap_fix(m, body, 0, 0, $urandom_range(0, 1) ? 2 : 4, 0, 1, 1);
      else if (pick < 85) begin
        keep = $urandom_range(0, 1);
        wrap_fix(m, body, 0, 0, 3, 0, keep, !keep);
      end else begin
        wrap_fix(m, body, 0, 0, 3, 0, 1, 1);
        if (pick < 90) begin
          // cut the message short
          keep = $urandom_range(1, m.size());
          while (m.size() > keep) void'(m.pop_back());
        end else if (pick < 95) begin
          m[$urandom_range(0, m.size() - 1)] = 8'($urandom_range(0, 255));
        end else begin
          push_text(m, "9=7|10=1");
        end
      end
      send_msg(m);
    end
  endtask

  task automatic test_no_idle_stretch();
    no_idle = 1'b1;
    test_random_messages(250);
    no_idle = 1'b0;
  endtask

  task automatic test_output_hold();
    hold_asked++;
    test_random_messages(150);
  endtask

  task automatic test_noise();
    logic [7:0] c;
    repeat (200) begin
      case ($urandom_range(0, 4))
        0: c = CH_8;
        1: c = CH_EQ;
        2: c = CH_SOH;
        3: c = CH_0 + 8'($urandom_range(0, 9));
        default: c = 8'($urandom_range(0, 255));
      endcase
      send_byte(c, $urandom_range(0, 19) == 0);
    end
    send_byte(CH_SOH, 1'b1);
  endtask

  initial begin
    parser_reset();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_start_checks();
    test_tag_errors();
    test_body_length_checks();
    test_good_messages();
    test_random_messages(850);
    test_no_idle_stretch();
    test_output_hold();
    test_noise();
    test_random_messages(150);
    test_long_value();

    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Sent %0d bytes in %0d messages; checked %0d result words, %0d summaries.",
             bytes_sent, messages_sent, words_checked, summaries);
    $display("Summaries: %0d with errors, %0d BodyLength matches, %0d CheckSum matches.",
             errored_msgs, body_matches, csum_matches);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/fix_tvp_pkg.sv
hdl/fix_tvp_parse.sv
hdl/fix_tvp_outq.sv
hdl/fix_tag_value_parser_core.sv
sim/tb_top.sv
